/* rtl/hfs_pkg.sv */
package hfs_pkg;

    localparam int NUM_STATES_DEF  = 8;
    localparam int NUM_SYMBOLS_DEF = 16;

    // probability format Q1.16, alpha format Q1.24
    localparam int PROB_FRAC_BITS = 16;
    localparam int ALPHA_FRAC     = 24;
    localparam int ALPHA_W        = 25;
    localparam int PROB_W         = 17;

    // reciprocal floor(2^48 / S)
    localparam int QW = 49;

    // log2 fraction bits, one squaring per bit
    localparam int SQ_STEPS = 20;
    localparam int L2W      = 27;

    localparam logic [31:0]        LN2_Q32  = 32'd2977044472;
    localparam logic signed [47:0] LL_ONE   = 48'sd65536;
    localparam logic signed [47:0] LL_MAX   = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] LL_MIN   = 48'sh8000_0000_0000;
    localparam logic [27:0]        SCALE_MAX = 28'hFFF_FFFF;

    typedef enum logic [1:0] {
        OP_LOAD_INIT  = 2'd0,
        OP_LOAD_TRANS = 2'd1,
        OP_LOAD_EMIS  = 2'd2,
        OP_OBSERVE    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        RES_DEAD = 2'd0,
        RES_LOW  = 2'd1,
        RES_LIVE = 2'd2
    } t_res_kind;

    typedef struct packed {
        logic      accept;
        logic      col_rd;
        logic      mac_issue;
        logic      emul;
        logic      store;
        logic      div_init;
        logic      div_step;
        logic      nrd;
        logic      nlo;
        logic      nhi;
        logic      nwr;
        logic      lnorm_init;
        logic      lnorm_step;
        logic      lsq_init;
        logic      lsq_step;
        logic      lmul;
        logic      lacc;
        logic      set_dead;
        logic      out_load;
        t_res_kind kind;
    } t_cmd;

    typedef struct packed {
        logic dead;
        logic s_low;
        logic norm_msb;
        logic out_free;
    } t_status;

endpackage

/* rtl/hfs_ctrl.sv */
module hfs_ctrl #(
    parameter int NUM_STATES = hfs_pkg::NUM_STATES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_opcode,
    input  logic              i_starts_sequence,
    input  hfs_pkg::t_status  i_st,
    output hfs_pkg::t_cmd     o_cmd,
    output logic [((NUM_STATES > 1) ? $clog2(NUM_STATES) : 1)-1:0] o_i_idx,
    output logic [((NUM_STATES > 1) ? $clog2(NUM_STATES) : 1)-1:0] o_j_idx,
    output logic [4:0]        o_bit
);

    localparam int SIW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam logic [SIW-1:0] LAST = SIW'(NUM_STATES - 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_COL, ST_MAC, ST_DRAIN, ST_EMUL, ST_STORE, ST_CHECK, ST_DIV,
        ST_NRD, ST_NLO, ST_NHI, ST_NWR, ST_LNORM, ST_LSQ, ST_LMUL, ST_LACC, ST_OUT
    } t_state;

    t_state             r_state;
    logic [SIW-1:0]     r_i;
    logic [SIW-1:0]     r_j;
    logic [5:0]         r_cnt;
    logic               r_start;
    hfs_pkg::t_res_kind r_kind;
    logic               accept;
    logic               obs;

    assign o_stall = (r_state != ST_IDLE);
    assign accept  = i_valid && !o_stall;
    assign obs     = (i_opcode == hfs_pkg::OP_OBSERVE);
    assign o_i_idx = r_i;
    assign o_j_idx = r_j;
    assign o_bit   = r_cnt[4:0];

    always_comb begin
        o_cmd            = '0;
        o_cmd.kind       = r_kind;
        o_cmd.accept     = accept;
        o_cmd.col_rd     = (r_state == ST_COL);
        o_cmd.mac_issue  = (r_state == ST_MAC);
        o_cmd.emul       = (r_state == ST_EMUL);
        o_cmd.store      = (r_state == ST_STORE);
        o_cmd.div_init   = (r_state == ST_CHECK) && !i_st.s_low;
        o_cmd.lnorm_init = (r_state == ST_CHECK) && !i_st.s_low;
        o_cmd.set_dead   = (r_state == ST_CHECK) && i_st.s_low;
        o_cmd.div_step   = (r_state == ST_DIV);
        o_cmd.nrd        = (r_state == ST_NRD);
        o_cmd.nlo        = (r_state == ST_NLO);
        o_cmd.nhi        = (r_state == ST_NHI);
        o_cmd.nwr        = (r_state == ST_NWR);
        o_cmd.lnorm_step = (r_state == ST_LNORM) && !i_st.norm_msb;
        o_cmd.lsq_init   = (r_state == ST_LNORM) && i_st.norm_msb;
        o_cmd.lsq_step   = (r_state == ST_LSQ);
        o_cmd.lmul       = (r_state == ST_LMUL);
        o_cmd.lacc       = (r_state == ST_LACC);
        o_cmd.out_load   = (r_state == ST_OUT) && i_st.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_cnt   <= '0;
            r_start <= 1'b0;
            r_kind  <= hfs_pkg::RES_DEAD;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept && obs) begin
                        r_start <= i_starts_sequence;
                        r_i     <= '0;
                        if (!i_starts_sequence && i_st.dead) begin
                            r_kind  <= hfs_pkg::RES_DEAD;
                            r_state <= ST_OUT;
                        end else begin
                            r_state <= ST_COL;
                        end
                    end
                end
                ST_COL: begin
                    r_j     <= '0;
                    r_state <= r_start ? ST_EMUL : ST_MAC;
                end
                ST_MAC: begin
                    if (r_j == LAST) begin
                        r_cnt   <= '0;
                        r_state <= ST_DRAIN;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    // drain the read stage, then the product stage
                    if (r_cnt == 6'd1) begin
                        r_state <= ST_EMUL;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                ST_EMUL: begin
                    r_state <= ST_STORE;
                end
                ST_STORE: begin
                    if (r_i == LAST) begin
                        r_state <= ST_CHECK;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= ST_COL;
                    end
                end
                ST_CHECK: begin
                    r_cnt <= '0;
                    if (i_st.s_low) begin
                        r_kind  <= hfs_pkg::RES_LOW;
                        r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_cnt == 6'(hfs_pkg::QW - 1)) begin
                        r_i     <= '0;
                        r_state <= ST_NRD;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                ST_NRD: begin
                    r_state <= ST_NLO;
                end
                ST_NLO: begin
                    r_state <= ST_NHI;
                end
                ST_NHI: begin
                    r_state <= ST_NWR;
                end
                ST_NWR: begin
                    if (r_i == LAST) begin
                        r_state <= ST_LNORM;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= ST_NRD;
                    end
                end
                ST_LNORM: begin
                    if (i_st.norm_msb) begin
                        r_cnt   <= 6'(hfs_pkg::SQ_STEPS - 1);
                        r_state <= ST_LSQ;
                    end
                end
                ST_LSQ: begin
                    if (r_cnt == 6'd0) begin
                        r_state <= ST_LMUL;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                ST_LMUL: begin
                    r_state <= ST_LACC;
                end
                ST_LACC: begin
                    r_kind  <= hfs_pkg::RES_LIVE;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (i_st.out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_st.out_free)
        else $error("result loaded over an untaken beat");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> !i_st.s_low)
        else $error("reciprocal of a scale below threshold");

    a_sq_normed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LSQ) |-> i_st.norm_msb)
        else $error("log squaring on an unnormalized scale");

endmodule

/* rtl/hfs_dp.sv */
module hfs_dp #(
    parameter int NUM_STATES  = hfs_pkg::NUM_STATES_DEF,
    parameter int NUM_SYMBOLS = hfs_pkg::NUM_SYMBOLS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [23:0]        i_cfg_wdata,
    input  logic [1:0]         i_opcode,
    input  logic [2:0]         i_row_index,
    input  logic [3:0]         i_col_index,
    input  logic [16:0]        i_prob_value,
    input  logic [3:0]         i_symbol,
    input  logic               i_starts_sequence,
    input  hfs_pkg::t_cmd      i_cmd,
    input  logic [((NUM_STATES > 1) ? $clog2(NUM_STATES) : 1)-1:0] i_i_idx,
    input  logic [((NUM_STATES > 1) ? $clog2(NUM_STATES) : 1)-1:0] i_j_idx,
    input  logic [4:0]         i_bit,
    output hfs_pkg::t_status   o_st,
    input  logic               i_stall,
    output logic               o_valid,
    output logic signed [47:0] o_log_likelihood,
    output logic               o_impossible,
    output logic [27:0]        o_step_scale
);

    localparam int F    = hfs_pkg::PROB_FRAC_BITS;
    localparam int LGN  = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 0;
    localparam int SIW  = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int TD   = NUM_STATES * NUM_STATES;
    localparam int ED   = NUM_STATES * NUM_SYMBOLS;
    localparam int TAW  = (TD > 1) ? $clog2(TD) : 1;
    localparam int EAW  = $clog2(ED);
    localparam int FW   = 25 + LGN;
    localparam int SW   = 25 + 2 * LGN;
    localparam int AW   = 41 + LGN;
    localparam int EPW  = FW + 17;
    localparam int CW   = (SW > 28) ? SW : 28;
    localparam int SHW  = $clog2(SW);
    localparam int QW   = hfs_pkg::QW;
    localparam int L2W  = hfs_pkg::L2W;
    localparam int LPW  = L2W + 32;
    localparam int AMW  = FW + 26;

    // ---- configuration and sequence state
    logic [23:0]        r_eps;
    logic               r_dead;
    logic signed [47:0] r_ll;
    logic               r_start;
    logic [3:0]         r_sym;

    logic load_init, load_trans, load_emis, obs_beat;
    logic row_ok, col_st_ok, col_sy_ok, sym_ok;
    logic [SIW-1:0] row_s;
    logic [TAW-1:0] trans_wa, trans_ra;
    logic [EAW-1:0] emis_wa, emis_ra;

    assign row_ok    = 32'(i_row_index) < NUM_STATES;
    assign col_st_ok = 32'(i_col_index) < NUM_STATES;
    assign col_sy_ok = 32'(i_col_index) < NUM_SYMBOLS;
    assign row_s     = SIW'(32'(i_row_index));
    assign trans_wa  = TAW'(32'(i_row_index) * NUM_STATES + 32'(i_col_index));
    assign emis_wa   = EAW'(32'(i_row_index) * NUM_SYMBOLS + 32'(i_col_index));
    assign trans_ra  = TAW'(32'(i_j_idx) * NUM_STATES + 32'(i_i_idx));
    assign emis_ra   = EAW'(32'(i_i_idx) * NUM_SYMBOLS + 32'(r_sym));
    assign sym_ok    = 32'(r_sym) < NUM_SYMBOLS;

    assign load_init  = i_cmd.accept && (i_opcode == hfs_pkg::OP_LOAD_INIT) && row_ok;
    assign load_trans = i_cmd.accept && (i_opcode == hfs_pkg::OP_LOAD_TRANS)
                        && row_ok && col_st_ok;
    assign load_emis  = i_cmd.accept && (i_opcode == hfs_pkg::OP_LOAD_EMIS)
                        && row_ok && col_sy_ok;
    assign obs_beat   = i_cmd.accept && (i_opcode == hfs_pkg::OP_OBSERVE);

    // ---- tables
    logic [16:0] r_init_mem  [NUM_STATES];
    logic [16:0] r_trans_mem [TD];
    logic [16:0] r_emis_mem  [ED];
    logic [24:0] r_alpha_mem [NUM_STATES];
    logic [FW-1:0] r_fresh_mem [NUM_STATES];

    logic [16:0]   r_pi_rd, r_b_rd, r_t_rd;
    logic [24:0]   r_a_rd;
    logic [FW-1:0] r_f_rd;

    always_ff @(posedge i_clk) begin
        if (load_init) begin
            r_init_mem[row_s] <= i_prob_value;
        end
        if (i_cmd.col_rd) begin
            r_pi_rd <= r_init_mem[i_i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_trans) begin
            r_trans_mem[trans_wa] <= i_prob_value;
        end
        if (i_cmd.mac_issue) begin
            r_t_rd <= r_trans_mem[trans_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_emis) begin
            r_emis_mem[emis_wa] <= i_prob_value;
        end
        if (i_cmd.col_rd) begin
            r_b_rd <= r_emis_mem[emis_ra];
        end
    end

    // ---- column sum pipeline: read, multiply, accumulate
    logic            r_v1, r_v2;
    logic [41:0]     r_mprod;
    logic [AW-1:0]   r_acc;
    logic [16:0]     b_val;
    logic [EPW-1:0]  r_eprod;
    logic [FW-1:0]   fresh_v;
    logic [SW-1:0]   r_s;

    assign b_val   = sym_ok ? r_b_rd : 17'd0;
    assign fresh_v = r_start ? FW'(r_eprod >> (2 * F - hfs_pkg::ALPHA_FRAC))
                             : FW'(r_eprod >> F);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.mac_issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mprod <= r_t_rd * r_a_rd;
        if (i_cmd.col_rd) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + AW'(r_mprod);
        end
        if (i_cmd.emul) begin
            if (r_start) begin
                r_eprod <= EPW'(r_pi_rd) * EPW'(b_val);
            end else begin
                r_eprod <= FW'(r_acc >> F) * b_val;
            end
        end
        if (obs_beat) begin
            r_s     <= '0;
            r_start <= i_starts_sequence;
            r_sym   <= i_symbol;
        end else if (i_cmd.store) begin
            r_s <= r_s + SW'(fresh_v);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_fresh_mem[i_i_idx] <= fresh_v;
        end
        if (i_cmd.nrd) begin
            r_f_rd <= r_fresh_mem[i_i_idx];
        end
    end

    // ---- restoring divider, one quotient bit per beat
    logic [SW:0]   r_rem;
    logic [QW-1:0] r_q, r_dvd;
    logic [SW:0]   trial;

    assign trial = {r_rem[SW-1:0], r_dvd[QW-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_q   <= '0;
            r_dvd <= {1'b1, {(QW - 1){1'b0}}};
        end else if (i_cmd.div_step) begin
            r_dvd <= r_dvd << 1;
            if (trial >= {1'b0, r_s}) begin
                r_rem <= trial - {1'b0, r_s};
                r_q   <= {r_q[QW-2:0], 1'b1};
            end else begin
                r_rem <= trial;
                r_q   <= {r_q[QW-2:0], 1'b0};
            end
        end
    end

    // ---- alpha normalize: two partial products of fresh * reciprocal
    logic [FW+23:0] r_plo;
    logic [FW+24:0] r_phi;
    logic [AMW-1:0] a_sum;
    logic [24:0]    a_sat;

    assign a_sum = AMW'(r_phi) + AMW'(r_plo >> 24);
    assign a_sat = (a_sum > AMW'(hfs_pkg::ALPHA_W'(1) << hfs_pkg::ALPHA_FRAC))
                   ? (25'd1 << hfs_pkg::ALPHA_FRAC) : a_sum[24:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.nlo) begin
            r_plo <= r_f_rd * r_q[23:0];
        end
        if (i_cmd.nhi) begin
            r_phi <= r_f_rd * r_q[QW-1:24];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.nwr) begin
            r_alpha_mem[i_i_idx] <= a_sat;
        end
        if (i_cmd.mac_issue) begin
            r_a_rd <= r_alpha_mem[i_j_idx];
        end
    end

    // ---- natural log of the scale
    logic [SW-1:0]          r_x;
    logic [SHW-1:0]         r_shc;
    logic [30:0]            r_m;
    logic signed [L2W-1:0]  r_l2;
    logic [SW+30:0]         x_pad;
    logic [61:0]            sq;
    logic [31:0]            sq_t;
    logic [L2W-1:0]         l2_mag;
    logic [LPW-1:0]         r_lprod;
    logic                   r_lneg;
    logic [LPW:0]           rnd;
    logic signed [48:0]     d_ext, ll_sum;

    assign x_pad  = {r_x, 31'd0};
    assign sq     = r_m * r_m;
    assign sq_t   = sq[61:30];
    assign l2_mag = r_l2[L2W-1] ? L2W'(-r_l2) : L2W'(r_l2);
    assign rnd    = (LPW + 1)'(r_lprod) + ((LPW + 1)'(1) << 35);
    assign d_ext  = r_lneg ? -$signed(49'(rnd[LPW:36])) : $signed(49'(rnd[LPW:36]));
    assign ll_sum = {r_ll[47], r_ll} + d_ext;

    always_ff @(posedge i_clk) begin
        if (i_cmd.lnorm_init) begin
            r_x   <= r_s;
            r_shc <= '0;
        end else if (i_cmd.lnorm_step) begin
            r_x   <= r_x << 1;
            r_shc <= r_shc + 1'b1;
        end
        if (i_cmd.lsq_init) begin
            r_m  <= x_pad[SW+30 -: 31];
            r_l2 <= (L2W'(SW - 25) - L2W'(r_shc)) <<< 20;
        end else if (i_cmd.lsq_step) begin
            if (sq_t[31]) begin
                r_m  <= sq_t[31:1];
                r_l2 <= r_l2 + (L2W'(1) << i_bit);
            end else begin
                r_m <= sq_t[30:0];
            end
        end
        if (i_cmd.lmul) begin
            r_lprod <= l2_mag * hfs_pkg::LN2_Q32;
            r_lneg  <= r_l2[L2W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps  <= 24'd1;
            r_dead <= 1'b0;
            r_ll   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_eps <= i_cfg_wdata;
            end
            if (obs_beat && i_starts_sequence) begin
                r_dead <= 1'b0;
                r_ll   <= '0;
            end else begin
                if (i_cmd.set_dead) begin
                    r_dead <= 1'b1;
                end
                if (i_cmd.lacc) begin
                    if (ll_sum[48] != ll_sum[47]) begin
                        r_ll <= ll_sum[48] ? hfs_pkg::LL_MIN : hfs_pkg::LL_MAX;
                    end else begin
                        r_ll <= ll_sum[47:0];
                    end
                end
            end
        end
    end

    // ---- result register
    logic          r_ov;
    logic [CW-1:0] s_ext;
    logic [27:0]   s_sat;

    assign s_ext = CW'(r_s);
    assign s_sat = (s_ext > CW'(hfs_pkg::SCALE_MAX)) ? hfs_pkg::SCALE_MAX : s_ext[27:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (r_ov && !i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.kind)
                hfs_pkg::RES_LIVE: begin
                    o_log_likelihood <= r_ll;
                    o_impossible     <= 1'b0;
                    o_step_scale     <= s_sat;
                end
                hfs_pkg::RES_LOW: begin
                    o_log_likelihood <= hfs_pkg::LL_ONE;
                    o_impossible     <= 1'b1;
                    o_step_scale     <= s_sat;
                end
                default: begin
                    o_log_likelihood <= hfs_pkg::LL_ONE;
                    o_impossible     <= 1'b1;
                    o_step_scale     <= '0;
                end
            endcase
        end
    end

    assign o_valid       = r_ov;
    assign o_st.dead     = r_dead;
    assign o_st.s_low    = (r_s == '0) || (r_s < SW'(r_eps));
    assign o_st.norm_msb = r_x[SW-1];
    assign o_st.out_free = !r_ov || !i_stall;

endmodule

/* rtl/hmm_forward_scaled.sv */
// Scaled forward pass of a discrete HMM. Input beats either load a table
// entry (initial, transition, emission; Q1.16, 65536 = 1.0; out-of-range
// indexes are dropped; no result) or observe one symbol (exactly one result
// beat). An observe with starts_sequence clears the log-likelihood and the
// impossible flag, then runs NUM_STATES columns of initial*emission. A
// continuation symbol runs NUM_STATES columns of NUM_STATES transition*alpha
// MACs (all on one multiplier fed from the transition table and alpha
// store). A live step then does a threshold check, restoring division for
// the reciprocal, alpha normalization of each state, a shift per leading
// zero of the scale to normalize it, 20 squaring steps for log2, the ln2
// multiply and saturating accumulate, and the load of the result. A step
// whose scale is zero or below eps_threshold answers impossible with
// log_likelihood = 1.0 and the sequence stays dead until the next start.
// Results sit in an output register, so the last beat may wait on i_stall
// while the next item is already accepted. eps_threshold is to be written
// through i_cfg_we / i_cfg_wdata only while idle (the user must keep to
// this; the block does not enforce it); it resets to 1.
module hmm_forward_scaled #(
    parameter int NUM_STATES  = hfs_pkg::NUM_STATES_DEF,
    parameter int NUM_SYMBOLS = hfs_pkg::NUM_SYMBOLS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration: eps_threshold, Q0.24
    input  logic               i_cfg_we,
    input  logic [23:0]        i_cfg_wdata,
    // input beats
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_opcode,
    input  logic [2:0]         i_row_index,
    input  logic [3:0]         i_col_index,
    input  logic [16:0]        i_prob_value,
    input  logic [3:0]         i_symbol,
    input  logic               i_starts_sequence,
    // result beats
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [47:0] o_log_likelihood,
    output logic               o_impossible,
    output logic [27:0]        o_step_scale
);

    localparam int SIW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;

    hfs_pkg::t_cmd    cmd;
    hfs_pkg::t_status st;
    logic [SIW-1:0]   i_idx;
    logic [SIW-1:0]   j_idx;
    logic [4:0]       sq_bit;

    // sequencer: column / MAC loops, divider and log iteration counts
    hfs_ctrl #(
        .NUM_STATES (NUM_STATES)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_opcode          (i_opcode),
        .i_starts_sequence (i_starts_sequence),
        .i_st              (st),
        .o_cmd             (cmd),
        .o_i_idx           (i_idx),
        .o_j_idx           (j_idx),
        .o_bit             (sq_bit)
    );

    // tables, alpha store, MAC, reciprocal, log and result register
    hfs_dp #(
        .NUM_STATES  (NUM_STATES),
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_opcode          (i_opcode),
        .i_row_index       (i_row_index),
        .i_col_index       (i_col_index),
        .i_prob_value      (i_prob_value),
        .i_symbol          (i_symbol),
        .i_starts_sequence (i_starts_sequence),
        .i_cmd             (cmd),
        .i_i_idx           (i_idx),
        .i_j_idx           (j_idx),
        .i_bit             (sq_bit),
        .o_st              (st),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_log_likelihood  (o_log_likelihood),
        .o_impossible      (o_impossible),
        .o_step_scale      (o_step_scale)
    );

endmodule

/* tb/testbench.sv */
module testbench;

    localparam int NS = 8;
    localparam int NY = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [23:0]        i_cfg_wdata = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_opcode = '0;
    logic [2:0]         i_row_index = '0;
    logic [3:0]         i_col_index = '0;
    logic [16:0]        i_prob_value = '0;
    logic [3:0]         i_symbol = '0;
    logic               i_starts_sequence = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [47:0] o_log_likelihood;
    logic               o_impossible;
    logic [27:0]        o_step_scale;

    hmm_forward_scaled dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_opcode(i_opcode), .i_row_index(i_row_index),
        .i_col_index(i_col_index), .i_prob_value(i_prob_value),
        .i_symbol(i_symbol), .i_starts_sequence(i_starts_sequence),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_log_likelihood(o_log_likelihood), .o_impossible(o_impossible),
        .o_step_scale(o_step_scale)
    );

    always #4 i_clk = ~i_clk;

    // one expected result beat
    typedef struct {
        logic signed [47:0] ll;
        logic               imp;
        logic [27:0]        scale;
    } t_forward_result;

    t_forward_result pending_results[$];

    // shadow copy of the model held by the block
    logic [23:0] eps_shadow;
    logic [16:0] pi_shadow [NS];
    logic [16:0] trans_shadow [NS*NS];
    logic [16:0] emis_shadow [NS*NY];
    logic [63:0] alpha_shadow [NS];
    logic signed [47:0] ll_shadow;
    logic        dead_shadow;

    int  errors = 0;
    int  n_items = 0;
    int  n_results = 0;
    int  n_dead = 0;
    int  idle_cnt = 0;
    bit  tx_idle_en = 1'b1;
    bit  rx_idle_en = 1'b1;
    bit  drv_on = 1'b0;   // i_valid is being driven high

    // ln(v / 2^24) in signed Q31.16, v >= 1
    function automatic logic signed [47:0] ln_of_scale(input logic [63:0] v);
        int k;
        logic [63:0] m;
        longint l2;
        logic [63:0] mag;
        logic [127:0] prod;
        k = 63;
        while (k > 0 && v[k] == 1'b0) k--;
        m = (k > 30) ? (v >> (k - 30)) : (v << (30 - k));
        l2 = longint'(k - 24) * (longint'(1) << 20);
        for (int i = 19; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                l2 += longint'(1) << i;
            end
        end
        if (l2 >= 0) begin
            prod = 128'(l2) * 128'(hfs_pkg::LN2_Q32) + (128'd1 << 35);
            mag = 64'(prod >> 36);
            return 48'(mag);
        end
        prod = 128'(-l2) * 128'(hfs_pkg::LN2_Q32) + (128'd1 << 35);
        mag = 64'(prod >> 36);
        return -48'(mag);
    endfunction

    // advance the forward recursion by one observed symbol
    function automatic t_forward_result forward_step(input logic [3:0] sym,
                                                     input logic start);
        t_forward_result res;
        logic [63:0] fresh [NS];
        logic [63:0] s, r, acc, b, a;
        logic signed [47:0] d;
        longint ll, dl;
        s = 0;
        if (start) begin
            ll_shadow = 0;
            dead_shadow = 1'b0;
        end else if (dead_shadow) begin
            res.ll = hfs_pkg::LL_ONE; res.imp = 1'b1; res.scale = 0;
            return res;
        end
        for (int i = 0; i < NS; i++) begin
            b = emis_shadow[i*NY + sym];
            if (start) begin
                fresh[i] = (64'(pi_shadow[i]) * b) >> 8;
            end else begin
                acc = 0;
                for (int j = 0; j < NS; j++)
                    acc += 64'(trans_shadow[j*NS + i]) * alpha_shadow[j];
                acc = acc >> hfs_pkg::PROB_FRAC_BITS;
                fresh[i] = (acc * b) >> hfs_pkg::PROB_FRAC_BITS;
            end
            s += fresh[i];
        end
        res.scale = (s > 64'(hfs_pkg::SCALE_MAX)) ? hfs_pkg::SCALE_MAX : s[27:0];
        if (s == 0 || s < 64'(eps_shadow)) begin
            dead_shadow = 1'b1;
            res.ll = hfs_pkg::LL_ONE; res.imp = 1'b1;
            return res;
        end
        r = (64'd1 << 48) / s;
        for (int i = 0; i < NS; i++) begin
            a = (fresh[i] * r) >> 24;
            alpha_shadow[i] = (a > 64'd16777216) ? 64'd16777216 : a;
        end
        d = ln_of_scale(s);
        dl = longint'(d);
        ll = longint'(ll_shadow);
        if (dl > 0 && ll > longint'(hfs_pkg::LL_MAX) - dl) ll = longint'(hfs_pkg::LL_MAX);
        else if (dl < 0 && ll < longint'(hfs_pkg::LL_MIN) - dl) ll = longint'(hfs_pkg::LL_MIN);
        else ll += dl;
        ll_shadow = 48'(ll);
        res.ll = ll_shadow; res.imp = 1'b0;
        return res;
    endfunction

    // drop valid once the last beat is taken
    task automatic release_input();
        if (drv_on) begin
            i_valid <= 1'b0;
            drv_on = 1'b0;
        end
    endtask

    // send one beat; updates the shadow model on acceptance
    task automatic send_beat(input hfs_pkg::t_opcode op, input logic [2:0] row,
                             input logic [3:0] col, input logic [16:0] prob,
                             input logic [3:0] sym, input logic start);
        int gap;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            release_input();
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        drv_on            = 1'b1;
        i_opcode          <= op;
        i_row_index       <= row;
        i_col_index       <= col;
        i_prob_value      <= prob;
        i_symbol          <= sym;
        i_starts_sequence <= start;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // accepted at this edge
        n_items++;
        case (op)
            hfs_pkg::OP_LOAD_INIT:  pi_shadow[row] = prob;
            hfs_pkg::OP_LOAD_TRANS: if (col < NS) trans_shadow[row*NS + col] = prob;
            hfs_pkg::OP_LOAD_EMIS:  emis_shadow[row*NY + col] = prob;
            hfs_pkg::OP_OBSERVE: begin
                pending_results.push_back(forward_step(sym, start));
            end
            default: ;
        endcase
    endtask

    // stop sending and wait until every expected result has come
    task automatic pause_until_drained();
        release_input();
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // wait for the block to drain, then write the threshold
    task automatic write_threshold(input logic [23:0] val);
        pause_until_drained();
        repeat (300) @(posedge i_clk);  // loads leave no result beat
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        eps_shadow = val;
    endtask

    // random probability, biased toward the ends of the range
    function automatic logic [16:0] rand_prob();
        case ($urandom_range(0, 7))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'(65536 - $urandom_range(0, 15));
            3: return 17'($urandom_range(0, 255));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic load_all_tables(input bit rnd);
        for (int i = 0; i < NS; i++)
            send_beat(hfs_pkg::OP_LOAD_INIT, 3'(i), 4'($urandom),
                      rnd ? rand_prob() : 17'd8192, 4'($urandom), 1'($urandom));
        for (int i = 0; i < NS; i++)
            for (int j = 0; j < NS; j++)
                send_beat(hfs_pkg::OP_LOAD_TRANS, 3'(i), 4'(j),
                          rnd ? rand_prob() : 17'd8192, 4'($urandom), 1'($urandom));
        for (int i = 0; i < NS; i++)
            for (int j = 0; j < NY; j++)
                send_beat(hfs_pkg::OP_LOAD_EMIS, 3'(i), 4'(j),
                          rnd ? rand_prob() : 17'd4096, 4'($urandom), 1'($urandom));
    endtask

    // result side: random stall bursts and checking
    initial begin : result_side
        int burst;
        t_forward_result want;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                n_results++;
                if (o_impossible) n_dead++;
                if (pending_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result beat");
                end else begin
                    want = pending_results.pop_front();
                    if (want.ll !== o_log_likelihood || want.imp !== o_impossible ||
                        want.scale !== o_step_scale) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp ll=%0d imp=%0b sc=%0d got ll=%0d imp=%0b sc=%0d",
                                     want.ll, want.imp, want.scale,
                                     o_log_likelihood, o_impossible, o_step_scale);
                    end
                end
            end
            if (burst > 0) begin
                burst--;
                i_stall <= (burst != 0);
            end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 13);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // directed: uniform model, extremes, out-of-range loads, dead handling
    task automatic test_directed();
        load_all_tables(1'b0);
        // out-of-range transition destination is dropped
        send_beat(hfs_pkg::OP_LOAD_TRANS, 3'd7, 4'd15, 17'd65536, 4'd0, 1'b0);
        send_beat(hfs_pkg::OP_OBSERVE, 3'd0, 4'd0, 17'd0, 4'd0, 1'b1);
        send_beat(hfs_pkg::OP_OBSERVE, 3'd7, 4'd15, 17'h1FFFF, 4'd15, 1'b0);
        send_beat(hfs_pkg::OP_OBSERVE, 3'd0, 4'd0, 17'd0, 4'd3, 1'b0);
        // zero emission on symbol 5: scale zero, sequence goes dead
        for (int i = 0; i < NS; i++)
            send_beat(hfs_pkg::OP_LOAD_EMIS, 3'(i), 4'd5, 17'd0, 4'd0, 1'b0);
        send_beat(hfs_pkg::OP_OBSERVE, 3'd0, 4'd0, 17'd0, 4'd5, 1'b0);
        send_beat(hfs_pkg::OP_OBSERVE, 3'd0, 4'd0, 17'd0, 4'd1, 1'b0);
        // full-scale model, emission one
        for (int i = 0; i < NS; i++) begin
            send_beat(hfs_pkg::OP_LOAD_INIT, 3'(i), 4'd0, 17'd65536, 4'd0, 1'b0);
            send_beat(hfs_pkg::OP_LOAD_EMIS, 3'(i), 4'd9, 17'd65536, 4'd0, 1'b0);
        end
        send_beat(hfs_pkg::OP_OBSERVE, 3'd0, 4'd0, 17'd0, 4'd9, 1'b1);
        send_beat(hfs_pkg::OP_OBSERVE, 3'd0, 4'd0, 17'd0, 4'd9, 1'b0);
    endtask

    // threshold extremes: zero, maximum, and 4096
    task automatic test_threshold();
        write_threshold(24'd0);
        send_beat(hfs_pkg::OP_OBSERVE, 3'd0, 4'd0, 17'd0, 4'd5, 1'b1);
        send_beat(hfs_pkg::OP_OBSERVE, 3'd0, 4'd0, 17'd0, 4'd9, 1'b1);
        write_threshold(24'hFFFFFF);
        send_beat(hfs_pkg::OP_OBSERVE, 3'd0, 4'd0, 17'd0, 4'd0, 1'b1);
        send_beat(hfs_pkg::OP_OBSERVE, 3'd0, 4'd0, 17'd0, 4'd9, 1'b1);
        write_threshold(24'd4096);
        send_beat(hfs_pkg::OP_OBSERVE, 3'd0, 4'd0, 17'd0, 4'd2, 1'b1);
    endtask

    // random sequences with the odd random table load in between
    task automatic test_random(input int n_obs);
        int left, len;
        logic [3:0] sym;
        left = n_obs;
        while (left > 0) begin
            if ($urandom_range(0, 5) == 0)
                send_beat(hfs_pkg::t_opcode'($urandom_range(0, 2)), 3'($urandom),
                          4'($urandom), rand_prob(), 4'($urandom), 1'($urandom));
            len = $urandom_range(1, 12);
            for (int k = 0; k < len && left > 0; k++) begin
                sym = 4'($urandom);
                send_beat(hfs_pkg::OP_OBSERVE, 3'($urandom), 4'($urandom), 17'($urandom),
                          sym, (k == 0) || ($urandom_range(0, 15) == 0));
                left--;
            end
        end
    endtask

    initial begin : stimulus
        eps_shadow = 24'd1;
        ll_shadow = 0;
        dead_shadow = 1'b0;
        for (int i = 0; i < NS; i++) begin
            pi_shadow[i] = 0;
            alpha_shadow[i] = 0;
        end
        for (int i = 0; i < NS*NS; i++) trans_shadow[i] = 0;
        for (int i = 0; i < NS*NY; i++) emis_shadow[i] = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_threshold();
        load_all_tables(1'b1);
        test_random(110);
        write_threshold(24'($urandom_range(1, 65536)));
        load_all_tables(1'b1);
        pause_until_drained();
        test_random(100);
        write_threshold(24'd1);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random(50);

        release_input();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("covered %0d input beats, %0d result beats (%0d impossible)",
                 n_items, n_results, n_dead);
        $display("loads, starts, continuations, dead sequences, threshold extremes");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule

/* sim.f */
rtl/hfs_pkg.sv
rtl/hfs_ctrl.sv
rtl/hfs_dp.sv
rtl/hmm_forward_scaled.sv
tb/testbench.sv
